### src/sector_request_splitter_chs_unit_assert.svh
// Assertion macros for the sector request splitter modules.
`ifndef SECTOR_REQUEST_SPLITTER_CHS_UNIT_ASSERT_SVH
`define SECTOR_REQUEST_SPLITTER_CHS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter check failed");

`endif

### src/srsc_pkg.sv
`default_nettype none

package srsc_pkg;

  // Fixed geometry of a request.
  localparam int unsigned SECTOR_BYTES      = 512;
  localparam int unsigned MAX_REQUEST_BYTES = 16384;
  localparam int unsigned OFF_W             = $clog2(SECTOR_BYTES);
  localparam int unsigned POS_W             = 32;
  localparam int unsigned CNT_W             = 15;
  localparam int unsigned REL_W             = POS_W + 1 - OFF_W;
  localparam int unsigned SPT_W             = 6;
  localparam int unsigned HC_W              = 9;
  localparam int unsigned HC_MAX            = 256;
  localparam int unsigned CFG_IDX_W         = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_PRESENT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHS_MODE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SECTOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT        = 3'd5;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_BEYOND = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SECT,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_EMIT
  } state_e;

  // Configuration as seen by the datapath, divisors already made legal.
  typedef struct packed {
    logic             drive_present;
    logic             chs_mode;
    logic [POS_W-1:0] first_sector;
    logic [POS_W-1:0] sector_count;
    logic [SPT_W-1:0] spt;
    logic [HC_W-1:0]  hc;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic sect;
    logic div_start;
    logic div_sel;
    logic latch_sec;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;
    logic chs;
    logic div_done;
    logic div_busy;
    logic last;
    logic out_free;
  } sts_t;

  // One result item.
  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] logical_sector;
    logic [15:0]      cyl_sector_word;
    logic [7:0]       head;
    logic [OFF_W-1:0] first_offset;
    logic [OFF_W-1:0] last_offset;
    logic             read_first;
    logic [CNT_W-1:0] bytes_so_far;
    logic [POS_W-1:0] new_position;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

### src/srsc_div.sv
`default_nettype none

// Restoring divider, two quotient bits per cycle.
module srsc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [srsc_pkg::POS_W-1:0]  dividend_i,
  input  wire logic [srsc_pkg::HC_W-1:0]   divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [srsc_pkg::POS_W-1:0]       quo_o,
  output logic [srsc_pkg::HC_W-1:0]        rem_o
);

  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned STEPS         = srsc_pkg::POS_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(STEPS);

  logic [srsc_pkg::POS_W-1:0] quo_q, quo_d;
  logic [srsc_pkg::HC_W-1:0]  rem_q, rem_d;
  logic [srsc_pkg::HC_W-1:0]  den_q;
  logic [STEP_W-1:0]          step_q;
  logic                       busy_q, done_q;

  // Two shift-and-subtract steps on the partial remainder.
  always_comb begin
    logic [srsc_pkg::HC_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {rem_d, quo_d[srsc_pkg::POS_W-1]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[srsc_pkg::POS_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[srsc_pkg::POS_W-2:0], 1'b0};
      end
      rem_d = trial[srsc_pkg::HC_W-1:0];
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### src/srsc_dp.sv
`default_nettype none

// Datapath: request registers, sector walk, CHS division and result register.
module srsc_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire srsc_pkg::cfg_t                  cfg_i,
  input  wire srsc_pkg::cmd_t                  cmd_i,
  output srsc_pkg::sts_t                       sts_o,
  input  wire logic [srsc_pkg::POS_W-1:0]      in_pos_i,
  input  wire logic [srsc_pkg::CNT_W-1:0]      in_count_i,
  input  wire logic                            in_write_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output srsc_pkg::result_t                    out_o
);

  localparam int unsigned POS_W = srsc_pkg::POS_W;
  localparam int unsigned CNT_W = srsc_pkg::CNT_W;
  localparam int unsigned OFF_W = srsc_pkg::OFF_W;
  localparam int unsigned REL_W = srsc_pkg::REL_W;
  localparam int unsigned HC_W  = srsc_pkg::HC_W;
  localparam int unsigned SPT_W = srsc_pkg::SPT_W;

  // Request registers.
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  n_q;
  logic              wr_q;
  srsc_pkg::status_e status_q;
  logic              single_q;
  logic [REL_W-1:0]  rel_q, rel1_q, rel2_q;
  logic [OFF_W-1:0]  off1_q, off2_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  sec_abs_q;
  logic [SPT_W-1:0]  track_sec_q;

  // Result register.
  srsc_pkg::result_t out_q, out_d;
  logic              out_valid_q;

  // Divider connections.
  logic [POS_W-1:0] div_quo;
  logic [HC_W-1:0]  div_rem;
  logic [POS_W-1:0] div_num;
  logic [HC_W-1:0]  div_den;
  logic             div_busy, div_done;

  // Setup terms.
  logic [POS_W:0]   pos2;
  logic [REL_W-1:0] rel2_raw;
  logic             clip, beyond;

  // Per-sector terms.
  logic             at_first, at_last;
  logic [OFF_W-1:0] a_off, b_off;
  logic [OFF_W:0]   nb;
  logic [CNT_W-1:0] cnt_d;

  assign div_num = cmd_i.div_sel ? div_quo : sec_abs_q;
  assign div_den = cmd_i.div_sel ? cfg_i.hc : HC_W'(cfg_i.spt);

  srsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Range of the request in relative sectors, clipped at the partition end.
  assign pos2     = {1'b0, pos_q} + (POS_W + 1)'(n_q) - (POS_W + 1)'(1);
  assign rel2_raw = pos2[POS_W:OFF_W];
  assign clip     = {{(POS_W - REL_W){1'b0}}, rel2_raw} >= cfg_i.sector_count;
  assign beyond   = {{OFF_W{1'b0}}, pos_q[POS_W-1:OFF_W]} >= cfg_i.sector_count;

  // Bytes of the current sector.
  assign at_first = rel_q == rel1_q;
  assign at_last  = rel_q == rel2_q;
  assign a_off    = at_first ? off1_q : '0;
  assign b_off    = at_last ? off2_q : OFF_W'(srsc_pkg::SECTOR_BYTES - 1);
  assign nb       = {1'b0, b_off} - {1'b0, a_off} + (OFF_W + 1)'(1);
  assign cnt_d    = cnt_q + CNT_W'(nb);

  // Request capture and setup.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= in_pos_i;
      n_q   <= (in_count_i > CNT_W'(srsc_pkg::MAX_REQUEST_BYTES))
             ? CNT_W'(srsc_pkg::MAX_REQUEST_BYTES) : in_count_i;
      wr_q  <= in_write_i;
    end
    if (cmd_i.setup) begin
      rel_q  <= REL_W'(pos_q[POS_W-1:OFF_W]);
      rel1_q <= REL_W'(pos_q[POS_W-1:OFF_W]);
      off1_q <= pos_q[OFF_W-1:0];
      cnt_q  <= '0;
      if (clip) begin
        rel2_q <= REL_W'(cfg_i.sector_count - POS_W'(1));
        off2_q <= OFF_W'(srsc_pkg::SECTOR_BYTES - 1);
      end else begin
        rel2_q <= rel2_raw;
        off2_q <= pos2[OFF_W-1:0];
      end
      if (!cfg_i.drive_present) begin
        status_q <= srsc_pkg::STATUS_ABSENT;
      end else if (beyond) begin
        status_q <= srsc_pkg::STATUS_BEYOND;
      end else begin
        status_q <= srsc_pkg::STATUS_OK;
      end
    end
    if (cmd_i.sect) begin
      sec_abs_q <= cfg_i.first_sector + POS_W'(rel_q);
    end
    if (cmd_i.latch_sec) begin
      track_sec_q <= div_rem[SPT_W-1:0] + SPT_W'(1);
    end
    if (cmd_i.emit) begin
      rel_q <= rel_q + REL_W'(1);
      cnt_q <= cnt_d;
    end
  end

  // Single-result flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 1'b0;
    end else if (cmd_i.setup) begin
      single_q <= !cfg_i.drive_present || beyond || (n_q == '0);
    end
  end

  // Next result.
  always_comb begin
    out_d              = '0;
    out_d.status       = status_q;
    out_d.new_position = pos_q;
    out_d.last         = 1'b1;
    if (!single_q) begin
      out_d.logical_sector = sec_abs_q;
      if (cfg_i.chs_mode) begin
        out_d.cyl_sector_word = {div_quo[7:0], div_quo[9:8], track_sec_q};
        out_d.head            = div_rem[7:0];
      end
      out_d.first_offset = a_off;
      out_d.last_offset  = b_off;
      out_d.read_first   = wr_q && (nb < (OFF_W + 1)'(srsc_pkg::SECTOR_BYTES));
      out_d.bytes_so_far = cnt_d;
      out_d.new_position = pos_q + POS_W'(cnt_d);
      out_d.last         = at_last;
    end
  end

  // Output register, freed as soon as its item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sts_o.single   = single_q;
  assign sts_o.chs      = cfg_i.chs_mode;
  assign sts_o.div_done = div_done;
  assign sts_o.div_busy = div_busy;
  assign sts_o.last     = single_q || at_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

### src/srsc_ctrl.sv
`default_nettype none

`include "sector_request_splitter_chs_unit_assert.svh"

// Controller: walks one request through setup, division and result hand-off.
module srsc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output srsc_pkg::cmd_t      cmd_o,
  input  wire srsc_pkg::sts_t sts_i
);

  srsc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = srsc_pkg::ST_SETUP;
        end
      end
      srsc_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = srsc_pkg::ST_SECT;
      end
      srsc_pkg::ST_SECT: begin
        if (sts_i.single) begin
          state_d = srsc_pkg::ST_EMIT;
        end else begin
          cmd_o.sect = 1'b1;
          state_d    = sts_i.chs ? srsc_pkg::ST_DIV1_GO : srsc_pkg::ST_EMIT;
        end
      end
      srsc_pkg::ST_DIV1_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = srsc_pkg::ST_DIV1_WAIT;
      end
      srsc_pkg::ST_DIV1_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_sec = 1'b1;
          state_d         = srsc_pkg::ST_DIV2_GO;
        end
      end
      srsc_pkg::ST_DIV2_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = srsc_pkg::ST_DIV2_WAIT;
      end
      srsc_pkg::ST_DIV2_WAIT: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          state_d = srsc_pkg::ST_EMIT;
        end
      end
      srsc_pkg::ST_EMIT: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? srsc_pkg::ST_IDLE : srsc_pkg::ST_SECT;
        end
      end
      default: begin
        state_d = srsc_pkg::ST_IDLE;
      end
    endcase
  end

  // A result is only loaded when the output register can take it.
  `SRSC_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd_o.emit, sts_i.out_free)
  // The divider is never restarted while it is still iterating.
  `SRSC_ASSERT_NOW(a_div_idle, clk_i, rst_ni, cmd_o.div_start, !sts_i.div_busy)
  // The final result of a request returns the controller to idle.
  `SRSC_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, cmd_o.emit && sts_i.last,
                    state_q == srsc_pkg::ST_IDLE)
  // A division finishing outside a wait state would be lost.
  `SRSC_ASSERT_NOW(a_done_wait, clk_i, rst_ni, sts_i.div_done,
                   state_q == srsc_pkg::ST_DIV1_WAIT || state_q == srsc_pkg::ST_DIV2_WAIT)

endmodule

`default_nettype wire

### src/sector_request_splitter_chs_unit.sv
// Splits a byte-range request on one partition into one command per 512-byte
// sector touched (up to 33 for the largest request of 16384 bytes), clipped at
// the partition end; an absent drive, a start past the end or a zero length
// give a single result. A request passes the accepting state and a setup state
// before its first sector; each sector then waits for a free output, and in CHS
// mode also for the shared divider, which retires two quotient bits a cycle and
// runs twice per sector (by sectors per track, then by heads). A new request is
// taken once the last command of the previous one sits in the output register.
`default_nettype none

module sector_request_splitter_chs_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [srsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  // Requests.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_position[31:0], byte_count[46:32], zero [47].
  input  wire logic [47:0]                    s_axis_tdata,
  // is_write[0].
  input  wire logic                           s_axis_tuser,
  // Sector commands.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // logical_sector[31:0], cyl_sector_word[47:32], head[55:48],
  // first_offset[64:56], last_offset[73:65], read_first[74],
  // bytes_so_far[89:75], new_position[121:90], zero [127:122].
  output logic [127:0]                        m_axis_tdata,
  // status[1:0].
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  logic                            drive_present_q;
  logic                            chs_mode_q;
  logic [srsc_pkg::POS_W-1:0]      first_sector_q;
  logic [srsc_pkg::POS_W-1:0]      sector_count_q;
  logic [srsc_pkg::SPT_W-1:0]      spt_q;
  logic [srsc_pkg::HC_W-1:0]       hc_q;
  srsc_pkg::cfg_t                  cfg;
  srsc_pkg::cmd_t                  cmd;
  srsc_pkg::sts_t                  sts;
  srsc_pkg::result_t               res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_present_q <= 1'b0;
      chs_mode_q      <= 1'b1;
      first_sector_q  <= '0;
      sector_count_q  <= 32'd2880;
      spt_q           <= 6'd18;
      hc_q            <= 9'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        srsc_pkg::REG_DRIVE_PRESENT:     drive_present_q <= cfg_data_i[0];
        srsc_pkg::REG_CHS_MODE:          chs_mode_q      <= cfg_data_i[0];
        srsc_pkg::REG_FIRST_SECTOR:      first_sector_q  <= cfg_data_i;
        srsc_pkg::REG_SECTOR_COUNT:      sector_count_q  <= cfg_data_i;
        srsc_pkg::REG_SECTORS_PER_TRACK: spt_q           <= cfg_data_i[srsc_pkg::SPT_W-1:0];
        srsc_pkg::REG_HEAD_COUNT:        hc_q            <= cfg_data_i[srsc_pkg::HC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Divisors of zero count as one; more than 256 heads count as 256.
  always_comb begin
    cfg.drive_present = drive_present_q;
    cfg.chs_mode      = chs_mode_q;
    cfg.first_sector  = first_sector_q;
    cfg.sector_count  = sector_count_q;
    cfg.spt           = (spt_q == '0) ? srsc_pkg::SPT_W'(1) : spt_q;
    if (hc_q == '0) begin
      cfg.hc = srsc_pkg::HC_W'(1);
    end else if (hc_q > srsc_pkg::HC_W'(srsc_pkg::HC_MAX)) begin
      cfg.hc = srsc_pkg::HC_W'(srsc_pkg::HC_MAX);
    end else begin
      cfg.hc = hc_q;
    end
  end

  srsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  srsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_pos_i    (s_axis_tdata[31:0]),
    .in_count_i  (s_axis_tdata[46:32]),
    .in_write_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res)
  );

  // Result packing.
  assign m_axis_tdata = {6'd0, res.new_position, res.bytes_so_far, res.read_first,
                         res.last_offset, res.first_offset, res.head,
                         res.cyl_sector_word, res.logical_sector};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // One request as the sender offers it.
  typedef struct packed {
    logic [31:0] start_position;
    logic [14:0] byte_count;
    logic        is_write;
  } request_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [srsc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  sector_request_splitter_chs_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Partition settings as the predictor sees them, at their reset values.
  logic        cfg_present = 1'b0;
  logic        cfg_chs     = 1'b1;
  logic [31:0] cfg_first   = 32'd0;
  logic [31:0] cfg_count   = 32'd2880;
  logic [5:0]  cfg_spt     = 6'd18;
  logic [8:0]  cfg_heads   = 9'd2;

  request_t          pending_requests[$];
  srsc_pkg::result_t expected_commands[$];
  int                mismatches = 0;

  // Sender and receiver bookkeeping.
  request_t    on_bus;
  bit          in_flight = 1'b0;
  int unsigned src_gap = 0;
  bit [31:0]   sent_count = 0;
  int unsigned sink_wait = 0;
  int unsigned sink_hold = 0;
  bit [31:0]   got_count = 0;

  // Work out the sector commands that one accepted request produces.
  function automatic void predict_commands(request_t req);
    logic [14:0] n;
    longint unsigned rel1, rel2, rel, last_byte;
    logic [8:0]  off_first, off_last;
    logic [31:0] sector, spt, heads, track, cyl, sec;
    logic [14:0] total;
    int          nb;
    srsc_pkg::result_t cmd;
    n = (req.byte_count > 15'(srsc_pkg::MAX_REQUEST_BYTES))
        ? 15'(srsc_pkg::MAX_REQUEST_BYTES) : req.byte_count;
    cmd = '0;
    cmd.status = srsc_pkg::STATUS_OK;
    cmd.new_position = req.start_position;
    cmd.last = 1'b1;
    rel1 = longint'(req.start_position) >> 9;
    // Absent drive, start past the end and zero length each give one empty command.
    if (!cfg_present || rel1 >= longint'(cfg_count) || n == 0) begin
      if (!cfg_present) cmd.status = srsc_pkg::STATUS_ABSENT;
      else if (rel1 >= longint'(cfg_count)) cmd.status = srsc_pkg::STATUS_BEYOND;
      expected_commands.push_back(cmd);
      return;
    end
    last_byte = longint'(req.start_position) + n - 1;
    rel2 = last_byte >> 9;
    off_last = last_byte[8:0];
    // Clip the range at the final sector of the partition.
    if (rel2 >= longint'(cfg_count)) begin
      rel2 = longint'(cfg_count) - 1;
      off_last = 9'd511;
    end
    off_first = req.start_position[8:0];
    spt = (cfg_spt == 0) ? 32'd1 : 32'(cfg_spt);
    heads = (cfg_heads == 0) ? 32'd1 : ((cfg_heads > 9'd256) ? 32'd256 : 32'(cfg_heads));
    total = '0;
    for (rel = rel1; rel <= rel2; rel++) begin
      cmd = '0;
      cmd.status = srsc_pkg::STATUS_OK;
      sector = cfg_first + 32'(rel);
      cmd.logical_sector = sector;
      cmd.first_offset = (rel == rel1) ? off_first : 9'd0;
      cmd.last_offset = (rel < rel2) ? 9'd511 : off_last;
      if (cfg_chs) begin
        sec = sector % spt + 1;
        track = sector / spt;
        cyl = (track / heads) & 32'h3FF;
        cmd.head = 8'(track % heads);
        cmd.cyl_sector_word = {cyl[7:0], cyl[9:8], sec[5:0]};
      end
      nb = int'(cmd.last_offset) - int'(cmd.first_offset) + 1;
      total = total + 15'(nb);
      cmd.read_first = req.is_write && nb < int'(srsc_pkg::SECTOR_BYTES);
      cmd.bytes_so_far = total;
      cmd.new_position = req.start_position + 32'(total);
      cmd.last = (rel == rel2);
      expected_commands.push_back(cmd);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: offers queued requests, with a random gap after each accepted item while bit 5 of the sent count is clear.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_flight = 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_commands(on_bus);
        sent_count++;
        in_flight = 1'b0;
        src_gap = sent_count[5] ? 0 : $urandom_range(0, 5);
      end
      if (!in_flight) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus = pending_requests.pop_front();
          in_flight = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, on_bus.byte_count, on_bus.start_position};
          s_axis_tuser <= on_bus.is_write;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each command against the oldest prediction and throttles ready.
  always @(posedge clk_i) begin
    srsc_pkg::result_t got;
    srsc_pkg::result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status          = srsc_pkg::status_e'(m_axis_tuser);
        got.logical_sector  = m_axis_tdata[31:0];
        got.cyl_sector_word = m_axis_tdata[47:32];
        got.head            = m_axis_tdata[55:48];
        got.first_offset    = m_axis_tdata[64:56];
        got.last_offset     = m_axis_tdata[73:65];
        got.read_first      = m_axis_tdata[74];
        got.bytes_so_far    = m_axis_tdata[89:75];
        got.new_position    = m_axis_tdata[121:90];
        got.last            = m_axis_tlast;
        if (expected_commands.size() == 0) begin
          $error("command with no request pending: sector %0h", got.logical_sector);
          mismatches++;
        end else begin
          want = expected_commands.pop_front();
          check_field("status", want.status, got.status);
          check_field("logical_sector", want.logical_sector, got.logical_sector);
          check_field("cyl_sector_word", want.cyl_sector_word, got.cyl_sector_word);
          check_field("head", want.head, got.head);
          check_field("first_offset", want.first_offset, got.first_offset);
          check_field("last_offset", want.last_offset, got.last_offset);
          check_field("read_first", want.read_first, got.read_first);
          check_field("bytes_so_far", want.bytes_so_far, got.bytes_so_far);
          check_field("new_position", want.new_position, got.new_position);
          check_field("last", want.last, got.last);
        end
        got_count++;
        // One long hold-off mid-run so the block backs up into its input.
        if (got_count == 150) sink_hold = 4000;
        else sink_wait = got_count[4] ? 0 : $urandom_range(0, 5);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Register write; called only while the block is idle.
  task automatic write_reg(logic [srsc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      srsc_pkg::REG_DRIVE_PRESENT:     cfg_present = value[0];
      srsc_pkg::REG_CHS_MODE:          cfg_chs = value[0];
      srsc_pkg::REG_FIRST_SECTOR:      cfg_first = value;
      srsc_pkg::REG_SECTOR_COUNT:      cfg_count = value;
      srsc_pkg::REG_SECTORS_PER_TRACK: cfg_spt = value[5:0];
      srsc_pkg::REG_HEAD_COUNT:        cfg_heads = value[8:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits are filled with noise.
  task automatic program_partition(logic present, logic chs, logic [31:0] first,
                                   logic [31:0] count, logic [5:0] spt, logic [8:0] heads);
    write_reg(srsc_pkg::REG_DRIVE_PRESENT, {31'($urandom()), present});
    write_reg(srsc_pkg::REG_CHS_MODE, {31'($urandom()), chs});
    write_reg(srsc_pkg::REG_FIRST_SECTOR, first);
    write_reg(srsc_pkg::REG_SECTOR_COUNT, count);
    write_reg(srsc_pkg::REG_SECTORS_PER_TRACK, {26'($urandom()), spt});
    write_reg(srsc_pkg::REG_HEAD_COUNT, {23'($urandom()), heads});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_flight || expected_commands.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_request(logic [31:0] pos, logic [14:0] len, logic wr);
    request_t req;
    req.start_position = pos;
    req.byte_count = len;
    req.is_write = wr;
    pending_requests.push_back(req);
  endfunction

  // Random request: mostly inside the partition, some near or past its end.
  function automatic request_t make_request();
    request_t        req;
    longint unsigned rel_lim, rel;
    int unsigned     pick;
    rel_lim = (cfg_count > 32'h7F_FFFF) ? 64'h80_0000 : longint'(cfg_count);
    pick = $urandom_range(0, 99);
    if (pick < 10 || rel_lim == 0) begin
      req.start_position = $urandom();
    end else begin
      if (pick < 25) rel = rel_lim - 1 - ($urandom_range(0, 3) % rel_lim);
      else if (pick < 33 && rel_lim < 64'h7F_FFFC) rel = rel_lim + $urandom_range(0, 3);
      else rel = $urandom() % rel_lim;
      req.start_position = 32'(rel * srsc_pkg::SECTOR_BYTES + $urandom_range(0, 511));
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) req.byte_count = '0;
    else if (pick < 45) req.byte_count = 15'($urandom_range(1, 700));
    else if (pick < 75) req.byte_count = 15'($urandom_range(1, 4096));
    else if (pick < 90) req.byte_count = 15'($urandom_range(4097, 16384));
    else if (pick < 95) req.byte_count = 15'(srsc_pkg::MAX_REQUEST_BYTES);
    else req.byte_count = 15'($urandom_range(16385, 32767));
    req.is_write = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Main sequence: reset, directed cases, then random phases under varied geometry.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drive absent after reset.
    push_request(32'd0, 15'd100, 1'b0);
    push_request(32'hFFFF_FFFF, 15'd16384, 1'b1);
    push_request(32'd512, 15'd0, 1'b0);
    wait_idle();

    // Floppy geometry.
    program_partition(1'b1, 1'b1, 32'd0, 32'd2880, 6'd18, 9'd2);
    push_request(32'd0, 15'd0, 1'b0);
    push_request(32'd0, 15'd1, 1'b0);
    push_request(32'd0, 15'd512, 1'b1);
    push_request(32'd1, 15'd511, 1'b1);
    push_request(32'd511, 15'd2, 1'b1);
    push_request(32'd0, 15'd16384, 1'b0);
    push_request(32'd1, 15'd16384, 1'b1);
    push_request(32'd100, 15'd32767, 1'b0);
    push_request(32'd0, 15'd16385, 1'b1);
    push_request(32'd2879 * 512 + 300, 15'd1000, 1'b1);
    push_request(32'd2880 * 512, 15'd10, 1'b0);
    push_request(32'd2880 * 512 - 1, 15'd1, 1'b0);
    push_request(32'hFFFF_FFFF, 15'd1, 1'b1);
    push_request(32'd17 * 512, 15'd1024, 1'b0);
    push_request(32'd35 * 512 + 7, 15'd600, 1'b1);
    wait_idle();

    // Plain LBA where both the sector number and the position wrap.
    program_partition(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 9'd256);
    push_request(32'hFFFF_FE00, 15'd1024, 1'b1);
    push_request(32'hFFFF_FFFF, 15'd16384, 1'b0);
    push_request(32'h5555_5555, 15'd513, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: program_partition(1'b1, 1'b0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 6'd0, 9'd0);
        1: program_partition(1'b1, 1'b1, $urandom(), $urandom_range(1, 5000), 6'd63, 9'd256);
        2: program_partition(1'b1, 1'b1, 32'd0, 32'd2880, 6'd0, 9'd0);
        3: program_partition(1'b1, 1'b1, $urandom(), $urandom(), 6'd1, 9'd511);
        4: program_partition(1'b1, 1'b1, 32'd0, 32'd0, 6'd18, 9'd2);
        5: program_partition(1'b1, 1'b1, 32'd100, 32'd1, 6'd18, 9'd2);
        6: program_partition(1'b0, 1'b1, $urandom(), $urandom(), 6'd18, 9'd2);
        7: program_partition(1'b1, 1'b1, $urandom(), 32'hFFFF_FFFF, 6'd63, 9'd1);
        default: program_partition(1'b1, 1'($urandom_range(0, 1)), $urandom(),
                                   $urandom_range(1, 100000), 6'($urandom_range(0, 63)),
                                   9'($urandom_range(0, 511)));
      endcase
      repeat (26) pending_requests.push_back(make_request());
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sector_request_splitter_chs_unit: match");
    end else begin
      $display("sector_request_splitter_chs_unit: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40_000_000;
    $display("sector_request_splitter_chs_unit: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/srsc_pkg.sv
src/srsc_div.sv
src/srsc_dp.sv
src/srsc_ctrl.sv
src/sector_request_splitter_chs_unit.sv
dv/testbench.sv
